FILE: rtl/core/upd_pkg.sv
// shared types, constants and helpers for the url percent decoder
package upd_pkg;

  // character codes
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] HexAlphaBase = 8'd10;

  // beats per bundle and default queue depth
  localparam int unsigned MaxBeats    = 3;
  localparam int unsigned QueueDepth  = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // results of one input byte, beats[0] goes out first
  typedef struct packed {
    logic [1:0]              cnt;
    out_beat_t [MaxBeats-1:0] beats;
  } bundle_t;

  // escape progress
  typedef enum logic [1:0] {
    PendNone  = 2'd0,
    PendPct   = 2'd1,
    PendDigit = 2'd2
  } pend_e;

  // front status seen by the top level
  typedef struct packed {
    pend_e pend;
  } front_stat_t;

  // back status seen by the top level
  typedef struct packed {
    logic [1:0] idx;
  } back_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= ChZero) && (c <= ChNine)) ||
           ((c >= ChLowA) && (c <= ChLowF)) ||
           ((c >= ChUpA)  && (c <= ChUpF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= ChZero) && (c <= ChNine)) begin
      v = c - ChZero;
    end else if ((c >= ChLowA) && (c <= ChLowF)) begin
      v = c - ChLowA + HexAlphaBase;
    end else if ((c >= ChUpA) && (c <= ChUpF)) begin
      v = c - ChUpA + HexAlphaBase;
    end
    return v[3:0];
  endfunction

endpackage

FILE: rtl/core/url_percent_decoder.sv
// top level of the streaming url percent decoder
// Decodes one encoded byte per cycle unless stalled: "%XY" (hex, either case)
// becomes one byte, '+' becomes a space, and a broken or cut-off escape is sent
// as a literal '%' followed by the held bytes handled again. The front end
// classifies each byte combinationally and writes its results (up to three beats)
// as one bundle into a two-entry queue; the back end sends one beat per cycle,
// unless stalled, through a registered output. Sustained rate is one input byte
// per cycle while each byte yields at most one beat; a byte yielding more holds
// the output until its beats are sent; the input stalls once the queue is full.
// Beats pass the queue, then the output register. No clearing pass after reset.
module url_percent_decoder #(
  parameter int unsigned QDepth = upd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  upd_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output upd_pkg::out_beat_t out_beat_o
);
  import upd_pkg::*;

  logic        q_full;
  logic        push;
  bundle_t     push_bundle;
  logic        head_valid;
  bundle_t     head;
  logic        pop;
  front_stat_t front_stat;
  back_stat_t  back_stat;

  upd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_beat_i     (in_beat_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_bundle_o (push_bundle),
    .stat_o        (front_stat)
  );

  upd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_bundle_i (push_bundle),
    .full_o        (q_full),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_beat_o   (out_beat_o),
    .stat_o       (back_stat)
  );

  // the end of a string leaves no escape pending
  a_last_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_beat_i.is_last) |=> (front_stat.pend == PendNone))
    else $error("escape still pending after end of string");

  // a held digit only follows a held percent sign, or stays while no beat comes
  a_digit_after_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_stat.pend == PendDigit) |->
      (($past(front_stat.pend) == PendPct) || ($past(front_stat.pend) == PendDigit)))
    else $error("hex digit held without a preceding percent sign");

  // beat index stays inside the head bundle
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> ((head.cnt != 2'd0) && (back_stat.idx < head.cnt)))
    else $error("beat index outside the head bundle");

  // an empty queue means the back end starts a fresh bundle
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid |-> (back_stat.idx == 2'd0))
    else $error("beat index left over with the queue empty");

endmodule

FILE: rtl/core/upd_front.sv
// front end: takes input beats, tracks escapes and builds result bundles
module upd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  upd_pkg::in_beat_t  in_beat_i,
  input  logic               q_full_i,
  output logic               push_o,
  output upd_pkg::bundle_t   push_bundle_o,
  output upd_pkg::front_stat_t stat_o
);
  import upd_pkg::*;

  pend_e      pend_q, pend_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       b_hex;
  logic       fresh_emit;
  logic       fresh_pend;
  logic [7:0] fresh_byte;
  bundle_t    bund;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_beat_i.in_byte;
  assign last       = in_beat_i.is_last;
  assign b_hex      = is_hex(b);

  // handling of the new byte with nothing held
  assign fresh_pend = (b == ChPercent) && !last;
  assign fresh_emit = !fresh_pend;
  assign fresh_byte = (b == ChPlus) ? ChSpace : b;

  // escape decoder
  always_comb begin
    pend_d = pend_q;
    held_d = held_q;
    bund   = '0;
    unique case (pend_q)
      PendPct: begin
        if (b_hex && !last) begin
          held_d = b;
          pend_d = PendDigit;
        end else begin
          bund.beats[0] = '{out_byte: ChPercent, out_last: 1'b0};
          bund.beats[1] = '{out_byte: fresh_byte, out_last: last};
          bund.cnt      = fresh_emit ? 2'd2 : 2'd1;
          pend_d        = fresh_pend ? PendPct : PendNone;
        end
      end
      PendDigit: begin
        held_d = 8'd0;
        if (b_hex) begin
          bund.beats[0] = '{out_byte: {hex_val(held_q), hex_val(b)}, out_last: last};
          bund.cnt      = 2'd1;
          pend_d        = PendNone;
        end else begin
          bund.beats[0] = '{out_byte: ChPercent, out_last: 1'b0};
          bund.beats[1] = '{out_byte: held_q, out_last: 1'b0};
          bund.beats[2] = '{out_byte: fresh_byte, out_last: last};
          bund.cnt      = fresh_emit ? 2'd3 : 2'd2;
          pend_d        = fresh_pend ? PendPct : PendNone;
        end
      end
      default: begin
        if (fresh_emit) begin
          bund.beats[0] = '{out_byte: fresh_byte, out_last: last};
          bund.cnt      = 2'd1;
        end
        pend_d = fresh_pend ? PendPct : PendNone;
      end
    endcase
  end

  assign push_o        = accept && (bund.cnt != 2'd0);
  assign push_bundle_o = bund;
  assign stat_o.pend   = pend_q;

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
      held_q <= 8'd0;
    end else if (accept) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule

FILE: rtl/core/upd_queue.sv
// short bundle queue between front and back
module upd_queue #(
  parameter int unsigned Depth = upd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  upd_pkg::bundle_t push_bundle_i,
  output logic             full_o,
  output logic             head_valid_o,
  output upd_pkg::bundle_t head_o,
  input  logic             pop_i
);
  import upd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  bundle_t        mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_bundle_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/upd_back.sv
// back end: sends the beats of each bundle through an output register
module upd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  upd_pkg::bundle_t     head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output upd_pkg::out_beat_t   out_beat_o,
  output upd_pkg::back_stat_t  stat_o
);
  import upd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  out_beat_t  beat_q;
  logic       load;
  logic       final_beat;

  // output register free or being emptied
  assign load       = head_valid_i && (!valid_q || !out_stall_i);
  assign final_beat = (idx_q == (head_i.cnt - 2'd1));
  assign pop_o      = load && final_beat;
  assign idx_d      = final_beat ? 2'd0 : idx_q + 2'd1;

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;
  assign stat_o.idx  = idx_q;

  // beat index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= head_i.beats[idx_q];
    end
  end

endmodule
